[sv/bcd_pkg.sv]
// Package for the push button click / long press decoder.
// Types, codes and constants shared by all modules; no dependencies.
package bcd_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int COUNT_WIDTH = 8;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    // countdown: positive counts, zero, or all ones for expired
    typedef logic signed [TIMER_WIDTH:0] rem_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic [31:0] FIRST_TIMEOUT_RESET = 32'd250;
    localparam logic [31:0] REPEAT_TIMEOUT_RESET = 32'd150;
    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam rem_t REM_EXPIRED = {(TIMER_WIDTH+1){1'b1}};

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_OTHER = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        EV_LONG_PRESS   = 2'd0,
        EV_SHORT_PRESS  = 2'd1,
        EV_LONG_RELEASE = 2'd2
    } ev_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FIRST_TIMEOUT  = 2'd0,
        CFG_REPEAT_TIMEOUT = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        timer_t first_timeout;
        timer_t repeat_timeout;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        ev_t    kind;
        count_t count;
    } res_t;

endpackage

[sv/bcd_cfg.sv]
// Configuration registers of the button decoder (timeouts).
// Depends on bcd_pkg.
module bcd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [bcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output bcd_pkg::cfg_t                       cfg
);

    bcd_pkg::timer_t first_reg, first_next;
    bcd_pkg::timer_t repeat_reg, repeat_next;

    always_comb
    begin
        first_next = first_reg;
        repeat_next = repeat_reg;
        if (cfg_valid)
        begin
            case (bcd_pkg::cfg_idx_t'(cfg_index))
                bcd_pkg::CFG_FIRST_TIMEOUT:  first_next = bcd_pkg::timer_t'(cfg_data);
                bcd_pkg::CFG_REPEAT_TIMEOUT: repeat_next = bcd_pkg::timer_t'(cfg_data);
                default: ;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= bcd_pkg::timer_t'(bcd_pkg::FIRST_TIMEOUT_RESET);
            repeat_reg <= bcd_pkg::timer_t'(bcd_pkg::REPEAT_TIMEOUT_RESET);
        end
        else
        begin
            first_reg <= first_next;
            repeat_reg <= repeat_next;
        end
    end

    assign cfg.first_timeout = first_reg;
    assign cfg.repeat_timeout = repeat_reg;

endmodule

[sv/bcd_core.sv]
// Decoder state (armed, countdown, clicks) and the combinational logic that updates it.
// Depends on bcd_pkg.
module bcd_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [1:0]    cmd,
    input  logic          level,
    input  bcd_pkg::cfg_t cfg,
    output bcd_pkg::res_t res
);

    logic            armed_reg, armed_next;
    bcd_pkg::rem_t   rem_reg, rem_next;
    bcd_pkg::count_t clicks_reg, clicks_next;

    logic            rem_pos;
    bcd_pkg::rem_t   rem_dec;
    bcd_pkg::rem_t   rem_first;
    bcd_pkg::rem_t   rem_repeat;

    assign rem_pos = !rem_reg[bcd_pkg::TIMER_WIDTH] && (rem_reg != '0);
    assign rem_dec = rem_pos ? (rem_reg - bcd_pkg::rem_t'(1)) : rem_reg;
    assign rem_first = bcd_pkg::rem_t'({1'b0, cfg.first_timeout});
    assign rem_repeat = bcd_pkg::rem_t'({1'b0, cfg.repeat_timeout});

    always_comb
    begin
        armed_next = armed_reg;
        rem_next = rem_reg;
        clicks_next = clicks_reg;
        res.valid = 1'b0;
        res.kind = bcd_pkg::EV_LONG_PRESS;
        res.count = '0;
        if (fire)
        begin
            case (bcd_pkg::cmd_t'(cmd))
                bcd_pkg::CMD_EDGE:
                begin
                    if (armed_reg)
                    begin
                        if (!level)
                        begin
                            if (rem_pos)
                            begin
                                if (clicks_reg != bcd_pkg::COUNT_MAX)
                                    clicks_next = clicks_reg + bcd_pkg::count_t'(1);
                                rem_next = rem_repeat;
                            end
                            else
                            begin
                                armed_next = 1'b0;
                                clicks_next = '0;
                                res.valid = 1'b1;
                                res.kind = bcd_pkg::EV_LONG_RELEASE;
                            end
                        end
                        else if (rem_pos)
                        begin
                            rem_next = rem_repeat;
                        end
                    end
                    else if (level)
                    begin
                        armed_next = 1'b1;
                        rem_next = rem_first;
                    end
                end
                bcd_pkg::CMD_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (rem_dec == '0)
                        begin
                            rem_next = bcd_pkg::REM_EXPIRED;
                            res.valid = 1'b1;
                            if (clicks_reg == '0)
                            begin
                                res.kind = bcd_pkg::EV_LONG_PRESS;
                            end
                            else
                            begin
                                res.kind = bcd_pkg::EV_SHORT_PRESS;
                                res.count = clicks_reg;
                                armed_next = 1'b0;
                                clicks_next = '0;
                            end
                        end
                        else
                        begin
                            rem_next = rem_dec;
                        end
                    end
                end
                bcd_pkg::CMD_OTHER:
                begin
                    // forced long press while the first countdown runs
                    if (rem_pos && (clicks_reg == '0))
                    begin
                        rem_next = bcd_pkg::REM_EXPIRED;
                        res.valid = 1'b1;
                        res.kind = bcd_pkg::EV_LONG_PRESS;
                    end
                end
                default: ;  // unused command code
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            rem_reg <= '0;
            clicks_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            rem_reg <= rem_next;
            clicks_reg <= clicks_next;
        end
    end

`ifndef SYNTH
    // a running countdown only exists while armed
    a_pos_armed: assert property (@(posedge clk) disable iff (!rst_n)
        rem_pos |-> armed_reg)
        else $error("countdown running while idle");

    // clicks are only held while armed
    a_clicks_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (clicks_reg != '0) |-> armed_reg)
        else $error("clicks held while idle");

    // no result without an item
    a_res_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> fire)
        else $error("result without item");
`endif

endmodule

[sv/button_click_long_press_decoder.sv]
// Top level of the push button click / long press decoder.
// Depends on bcd_pkg, bcd_cfg and bcd_core.
//
// Usage:
//   Input channel (in_valid / in_stall, command, button_level): one beat is a
//   button edge with its new level, a time tick, or an other-event notice.
//   Output channel (out_valid / out_stall, event_kind, click_count): one beat
//   per reported event (long press, short press with count, long release).
//   Most input beats produce no output beat.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes the
//   first and repeat timeouts; cfg_ready is always high. Write only while
//   the block is idle.
// Timing:
//   A beat lands in the input register, is decoded there against the core
//   state once the output slot is free, and its event, if any, is written
//   into the output register. One beat per cycle is taken while in_stall is
//   low; the state update is combinational logic.
// Reset:
//   rst_n clears the state to idle, the timeouts to 250 and 150 ticks, and
//   empties both registers.
// Stall:
//   While out_stall holds a waiting event, the input register keeps its beat
//   and in_stall rises once it is full; nothing is dropped.
module button_click_long_press_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          command,
    input  logic                                button_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          event_kind,
    output logic [7:0]                          click_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    bcd_pkg::cfg_t cfg;
    bcd_pkg::res_t res;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_cmd_reg;
    logic       in_level_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    bcd_pkg::ev_t                out_kind_reg;
    logic [bcd_pkg::COUNT_WIDTH-1:0] out_count_reg;

    logic out_free;
    logic consume;
    logic in_take;

    assign cfg_ready = 1'b1;

    bcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // output slot empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign consume = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !consume;
    assign in_take = in_valid && !in_stall;

    bcd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (consume),
        .cmd   (in_cmd_reg),
        .level (in_level_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= command;
            in_level_reg <= button_level;
        end
        if (out_free && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_count_reg <= res.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign click_count = out_count_reg;

`ifndef SYNTH
    // a short press always carries at least one click
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == bcd_pkg::EV_SHORT_PRESS)) |->
            (out_count_reg != '0))
        else $error("short press with zero clicks");

    // long press and long release carry no count
    a_long_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != bcd_pkg::EV_SHORT_PRESS)) |->
            (out_count_reg == '0))
        else $error("long event with nonzero count");

    // a stalled input beat stays in the input register
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("stalled input beat lost");
`endif

endmodule
